// File: rtl/icr_pkg.sv
package icr_pkg;

    localparam int POINT_CAPACITY = 64;
    localparam int ADDR_W = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
    localparam int CNT_W = $clog2(POINT_CAPACITY + 1);
    localparam int INT_W = 21;
    localparam int DIV_W = INT_W + 1;
    localparam int FRAC_W = 16;
    localparam int STEP_W = $clog2(FRAC_W);
    localparam int T_W = FRAC_W + 1;
    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [INT_W-1:0] INT_MAX = 21'sd999999;
    localparam logic signed [INT_W-1:0] INT_MIN = -21'sd999999;
    localparam logic signed [INT_W-1:0] HIGH_BOUND_RST = 21'sd4096;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTO_BOUNDS = 3'd0,
        REG_LOW_BOUND   = 3'd1,
        REG_HIGH_BOUND  = 3'd2,
        REG_LOW_COLOR   = 3'd3,
        REG_HIGH_COLOR  = 3'd4
    } cfg_reg_t;

    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W-1:0] v);
        logic signed [INT_W-1:0] r;
        r = v;
        if (v > INT_MAX)
        begin
            r = INT_MAX;
        end
        else if (v < INT_MIN)
        begin
            r = INT_MIN;
        end
        return r;
    endfunction

    // (L << 16) + (H - L) * t + half, rounded half up
    function automatic logic [7:0] blend_ch(input logic [7:0] h, input logic [7:0] l,
                                            input logic [T_W-1:0] t);
        logic signed [8:0]  dch;
        logic signed [26:0] prod;
        logic signed [26:0] acc;
        dch  = $signed({1'b0, h}) - $signed({1'b0, l});
        prod = dch * $signed({1'b0, t});
        acc  = prod + $signed({3'b000, l, 16'h8000});
        return acc[23:16];
    endfunction

endpackage

// File: rtl/icr_ram.sv
module icr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/icr_div.sv
module icr_div
    import icr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] num,
    input  logic signed [DIV_W-1:0] den,
    output logic                    done,
    output logic [T_W-1:0]          t
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_PREP = 3'b010,
        D_ITER = 3'b100
    } div_state_t;

    div_state_t          state_reg, state_next;
    logic [DIV_W-1:0]    a_reg, a_next;
    logic [DIV_W-1:0]    d_reg, d_next;
    logic                zero_reg, zero_next;
    logic [DIV_W-1:0]    r_reg, r_next;
    logic [FRAC_W-1:0]   q_reg, q_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                done_reg, done_next;
    logic [T_W-1:0]      t_reg, t_next;
    logic [DIV_W:0]      r_shift;

    assign done = done_reg;
    assign t    = t_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        zero_next  = zero_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        t_next     = t_reg;
        r_shift    = {r_reg, 1'b0};
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    a_next     = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
                    d_next     = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
                    // opposite signs or a zero term clamp to zero
                    zero_next  = (num == '0) || (den == '0) || (num[DIV_W-1] ^ den[DIV_W-1]);
                    state_next = D_PREP;
                end
            end
            D_PREP:
            begin
                if (zero_reg)
                begin
                    t_next     = '0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else if (a_reg >= d_reg)
                begin
                    t_next     = T_ONE;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    r_next     = a_reg;
                    q_next     = '0;
                    step_next  = '0;
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                if (r_shift >= {1'b0, d_reg})
                begin
                    r_next = DIV_W'(r_shift - {1'b0, d_reg});
                    q_next = {q_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = DIV_W'(r_shift);
                    q_next = {q_reg[FRAC_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRAC_W - 1))
                begin
                    t_next     = {1'b0, q_next};
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        d_reg    <= d_next;
        zero_reg <= zero_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        t_reg    <= t_next;
    end

endmodule

// File: rtl/intensity_to_color_ramp.sv
// Intensity to colour ramp.
// Input stream s_*: one transaction per point, tdata[20:0] = signed intensity,
// tlast marks the last point of a frame. Points are written to a 64-entry
// store while s_tready is high; points beyond capacity are dropped and flagged.
// The frame's last point starts emission: one output transaction per stored
// point, in arrival order, with tlast on the final one. s_tready stays low
// until the final result has been loaded into the output register.
// Each result passes through the store read, the divider start, the
// shift-subtract divider (which ends early when the quotient clamps) and
// the blend into the output register. The divider for the next point runs
// while a result waits in the output register; a stall on m_tready holds
// the result and stops the sequence after that division.
// cfg_*: register writes (index 0 auto_bounds .. 4 high_color), always ready;
// write only while no frame is being emitted. In auto mode the frame's bounds
// are written back to low_bound/high_bound.
// Reset clears the frame (empty store, running bounds at their limits) and
// loads the register defaults; no clearing pass is needed.
module intensity_to_color_ramp
    import icr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [20:0] intensity
    input  logic                 s_tlast,   // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // red, green, blue, used_low, used_high
    output logic                 m_tlast,   // last_point
    output logic [0:0]           m_tuser,   // overflowed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    typedef enum logic [5:0] {
        ST_COLLECT = 6'b000001,
        ST_READ    = 6'b000010,
        ST_LOAD    = 6'b000100,
        ST_START   = 6'b001000,
        ST_DIV     = 6'b010000,
        ST_OUT     = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    auto_reg, auto_next;
    logic signed [INT_W-1:0] low_bound_reg, low_bound_next;
    logic signed [INT_W-1:0] high_bound_reg, high_bound_next;
    logic [COLOR_W-1:0]      low_color_reg, low_color_next;
    logic [COLOR_W-1:0]      high_color_reg, high_color_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [INT_W-1:0] run_lo_reg, run_lo_next;
    logic signed [INT_W-1:0] run_hi_reg, run_hi_next;
    logic                    drop_reg, drop_next;
    logic signed [INT_W-1:0] lo_reg, lo_next;
    logic signed [INT_W-1:0] hi_reg, hi_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        emit_n_reg, emit_n_next;
    logic [ADDR_W-1:0]       rd_idx_reg, rd_idx_next;
    logic signed [DIV_W-1:0] diff_reg, diff_next;
    logic signed [DIV_W-1:0] num_reg, num_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_last_reg, m_last_next;
    logic                    m_ovf_reg, m_ovf_next;
    logic [7:0]              red_reg, red_next;
    logic [7:0]              green_reg, green_next;
    logic [7:0]              blue_reg, blue_next;
    logic signed [INT_W-1:0] used_lo_reg, used_lo_next;
    logic signed [INT_W-1:0] used_hi_reg, used_hi_next;

    logic                    in_accept;
    logic                    full;
    logic signed [INT_W-1:0] v;
    logic signed [INT_W-1:0] run_lo_upd;
    logic signed [INT_W-1:0] run_hi_upd;
    logic                    is_last;
    logic                    out_free;
    logic [INT_W-1:0]        ram_rdata;
    logic                    div_start;
    logic                    div_done;
    logic [T_W-1:0]          div_t;

    assign s_tready  = (state_reg == ST_COLLECT);
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(POINT_CAPACITY));
    assign v         = sat_int($signed(s_tdata[INT_W-1:0]));
    assign run_lo_upd = (!full && (v < run_lo_reg)) ? v : run_lo_reg;
    assign run_hi_upd = (!full && (v > run_hi_reg)) ? v : run_hi_reg;
    assign is_last   = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == emit_n_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign div_start = (state_reg == ST_START);

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;
    assign m_tdata  = {6'b000000, used_hi_reg, used_lo_reg, blue_reg, green_reg, red_reg};

    icr_ram #(
        .WIDTH (INT_W),
        .DEPTH (POINT_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (in_accept && !full),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (v),
        .re    (state_reg == ST_READ),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    icr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (diff_reg),
        .done  (div_done),
        .t     (div_t)
    );

    always_comb
    begin
        state_next      = state_reg;
        auto_next       = auto_reg;
        low_bound_next  = low_bound_reg;
        high_bound_next = high_bound_reg;
        low_color_next  = low_color_reg;
        high_color_next = high_color_reg;
        count_next      = count_reg;
        run_lo_next     = run_lo_reg;
        run_hi_next     = run_hi_reg;
        drop_next       = drop_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ovf_next        = ovf_reg;
        emit_n_next     = emit_n_reg;
        rd_idx_next     = rd_idx_reg;
        diff_next       = diff_reg;
        num_next        = num_reg;
        m_valid_next    = m_valid_reg;
        m_last_next     = m_last_reg;
        m_ovf_next      = m_ovf_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        used_lo_next    = used_lo_reg;
        used_hi_next    = used_hi_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (in_accept)
                begin
                    if (s_tlast)
                    begin
                        if (auto_reg)
                        begin
                            lo_next         = run_lo_upd;
                            hi_next         = run_hi_upd;
                            low_bound_next  = run_lo_upd;
                            high_bound_next = run_hi_upd;
                        end
                        else
                        begin
                            lo_next = sat_int(low_bound_reg);
                            hi_next = sat_int(high_bound_reg);
                        end
                        emit_n_next = full ? count_reg : count_reg + CNT_W'(1);
                        ovf_next    = drop_reg || full;
                        rd_idx_next = '0;
                        count_next  = '0;
                        run_lo_next = INT_MAX;
                        run_hi_next = INT_MIN;
                        drop_next   = 1'b0;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        run_lo_next = run_lo_upd;
                        run_hi_next = run_hi_upd;
                        if (full)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_READ:
            begin
                diff_next  = {hi_reg[INT_W-1], hi_reg} - {lo_reg[INT_W-1], lo_reg};
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                num_next   = {ram_rdata[INT_W-1], ram_rdata} - {lo_reg[INT_W-1], lo_reg};
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    red_next     = blend_ch(high_color_reg[23:16], low_color_reg[23:16], div_t);
                    green_next   = blend_ch(high_color_reg[15:8], low_color_reg[15:8], div_t);
                    blue_next    = blend_ch(high_color_reg[7:0], low_color_reg[7:0], div_t);
                    used_lo_next = lo_reg;
                    used_hi_next = hi_reg;
                    m_ovf_next   = ovf_reg;
                    m_last_next  = is_last;
                    m_valid_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AUTO_BOUNDS: auto_next       = cfg_data[0];
                REG_LOW_BOUND:   low_bound_next  = $signed(cfg_data[INT_W-1:0]);
                REG_HIGH_BOUND:  high_bound_next = $signed(cfg_data[INT_W-1:0]);
                REG_LOW_COLOR:   low_color_next  = cfg_data;
                REG_HIGH_COLOR:  high_color_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            auto_reg       <= 1'b1;
            low_bound_reg  <= '0;
            high_bound_reg <= HIGH_BOUND_RST;
            low_color_reg  <= '0;
            high_color_reg <= '1;
            count_reg      <= '0;
            run_lo_reg     <= INT_MAX;
            run_hi_reg     <= INT_MIN;
            drop_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            emit_n_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            auto_reg       <= auto_next;
            low_bound_reg  <= low_bound_next;
            high_bound_reg <= high_bound_next;
            low_color_reg  <= low_color_next;
            high_color_reg <= high_color_next;
            count_reg      <= count_next;
            run_lo_reg     <= run_lo_next;
            run_hi_reg     <= run_hi_next;
            drop_reg       <= drop_next;
            rd_idx_reg     <= rd_idx_next;
            emit_n_reg     <= emit_n_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        ovf_reg     <= ovf_next;
        diff_reg    <= diff_next;
        num_reg     <= num_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        used_lo_reg <= used_lo_next;
        used_hi_reg <= used_hi_next;
    end

endmodule
